// File: rtl/tmf_pkg.sv
// Package for the tensor mean diffusivity / fractional anisotropy block.
// Holds default widths used by the design modules; depends on nothing.
package tmf_pkg;
    localparam int COMP_WIDTH_DEF   = 16;
    localparam int FA_FRAC_BITS_DEF = 16;
    localparam int OUT_WIDTH        = 16;
    localparam int ROOT_BITS        = 16;
endpackage

// File: rtl/tmf_front.sv
// Front stages: squares, trace, norm S, numerator 3S - T^2 and mean diffusivity.
// Depends on tmf_pkg.
module tmf_front #(
    parameter int CW = tmf_pkg::COMP_WIDTH_DEF,
    parameter int SW = 2 * CW + 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] xx,
    input  logic signed [CW-1:0] xy,
    input  logic signed [CW-1:0] xz,
    input  logic signed [CW-1:0] yy,
    input  logic signed [CW-1:0] yz,
    input  logic signed [CW-1:0] zz,
    output logic                 out_valid,
    output logic [SW-1:0]        s_out,
    output logic [SW-1:0]        num_out,
    output logic signed [15:0]   md_out
);
    import tmf_pkg::*;
    localparam int PW = 2 * CW;
    localparam int TW = CW + 2;

    logic              v1_reg, v2_reg;
    logic [PW-1:0]     q_reg [6];
    logic signed [TW-1:0] tr_reg;
    logic [SW-1:0]     s_reg;
    logic [SW-1:0]     s_next;
    logic [2*TW-1:0]   t2_next;
    logic [SW-1:0]     num_reg;
    logic signed [15:0] md_reg;
    logic signed [TW-1:0] tr_next;
    logic signed [TW-1:0] md_full;
    logic [TW-1:0]     tmag;

    function automatic logic [PW-1:0] sq(input logic signed [CW-1:0] a);
        logic [CW-1:0] m;
        m = a[CW-1] ? CW'(-a) : CW'(a);
        return PW'(m) * PW'(m);
    endfunction

    assign tr_next = TW'(xx) + TW'(yy) + TW'(zz);
    assign s_next = SW'(q_reg[0]) + SW'(q_reg[3]) + SW'(q_reg[5])
                  + (SW'(q_reg[1]) << 1) + (SW'(q_reg[2]) << 1) + (SW'(q_reg[4]) << 1);
    assign tmag = tr_reg[TW-1] ? TW'(-tr_reg) : TW'(tr_reg);
    assign t2_next = (2*TW)'(tmag) * (2*TW)'(tmag);
    assign md_full = TW'(tr_reg / 3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            q_reg[0] <= sq(xx);
            q_reg[1] <= sq(xy);
            q_reg[2] <= sq(xz);
            q_reg[3] <= sq(yy);
            q_reg[4] <= sq(yz);
            q_reg[5] <= sq(zz);
            tr_reg   <= tr_next;
            s_reg    <= s_next;
            num_reg  <= SW'(3 * s_next) - SW'(t2_next);
            if (md_full > TW'(32767)) md_reg <= 16'sh7fff;
            else if (md_full < -TW'(32768)) md_reg <= -16'sh8000;
            else md_reg <= 16'(md_full);
        end
    end

    assign out_valid = v2_reg;
    assign s_out     = s_reg;
    assign num_out   = num_reg;
    assign md_out    = md_reg;
endmodule

// File: rtl/tmf_sqrt.sv
// Pipelined restoring root search: one result bit per stage.
// Finds largest r with r^2 * 2S <= num * 2^(2F). Depends on tmf_pkg.
module tmf_sqrt #(
    parameter int SW = 36,
    parameter int FB = tmf_pkg::FA_FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [SW-1:0] s_in,
    input  logic [SW-1:0] num_in,
    input  logic [15:0]   md_in,
    output logic          out_valid,
    output logic [15:0]   fa_out,
    output logic          zero_out,
    output logic [15:0]   md_out
);
    import tmf_pkg::*;
    localparam int N   = ROOT_BITS;
    localparam int LW  = SW + 2 * FB;
    localparam int PW  = SW + 1 + 2 * N;
    localparam int CW2 = (PW > LW) ? PW : LW;

    logic           v_reg  [N+1];
    logic [CW2-1:0] d_reg  [N+1];
    logic [CW2-1:0] l_reg  [N+1];
    logic [CW2-1:0] p_reg  [N+1];
    logic [CW2-1:0] q_reg  [N+1];
    logic [N-1:0]   r_reg  [N+1];
    logic [15:0]    m_reg  [N+1];

    // The running products 2S*r^2 and 2S*r are kept so that each stage only adds.
    always_comb begin
        v_reg[0] = in_valid;
        d_reg[0] = CW2'(s_in) << 1;
        l_reg[0] = CW2'(num_in) << (2 * FB);
        p_reg[0] = '0;
        q_reg[0] = '0;
        r_reg[0] = '0;
        m_reg[0] = md_in;
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int B = N - 1 - k;
        logic [N-1:0]   t;
        logic [CW2-1:0] trial;
        logic           take;
        assign t     = r_reg[k] | (N'(1) << B);
        assign trial = p_reg[k] + (q_reg[k] << (B + 1)) + (d_reg[k] << (2 * B));
        assign take  = (trial <= l_reg[k]) && (d_reg[k] != '0);
        always_ff @(posedge aclk) begin
            if (!aresetn) v_reg[k+1] <= 1'b0;
            else if (en) v_reg[k+1] <= v_reg[k];
            if (en) begin
                d_reg[k+1] <= d_reg[k];
                l_reg[k+1] <= l_reg[k];
                m_reg[k+1] <= m_reg[k];
                r_reg[k+1] <= take ? t : r_reg[k];
                p_reg[k+1] <= take ? trial : p_reg[k];
                q_reg[k+1] <= take ? q_reg[k] + (d_reg[k] << B) : q_reg[k];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign fa_out    = 16'(r_reg[N]);
    assign zero_out  = (d_reg[N] == '0);
    assign md_out    = m_reg[N];
endmodule

// File: rtl/tensor_md_fa.sv
// Top level: mean diffusivity and fractional anisotropy of one tensor per cycle while the output is not stalled.
// An input request passes the front stages, then the root stages, then the output register.
// The whole pipeline advances when the output register is free or being emptied.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not reset.
// Depends on tmf_pkg, tmf_front and tmf_sqrt.
module tensor_md_fa #(
    parameter int COMP_WIDTH   = tmf_pkg::COMP_WIDTH_DEF,
    parameter int FA_FRAC_BITS = tmf_pkg::FA_FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // dxx, dxy, dxz, dyy, dyz, dzz from bit 0 up
    input  logic [((6*COMP_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // mean_diff [15:0], frac_aniso [31:16]
    output logic [31:0]             m_tdata,
    // zero_tensor
    output logic                    m_tuser
);
    import tmf_pkg::*;
    localparam int CW = COMP_WIDTH;
    localparam int SW = 2 * CW + 4;

    logic en;
    logic f_v, q_v, q_z;
    logic [SW-1:0] f_s, f_n;
    logic signed [15:0] f_md;
    logic [15:0] q_fa, q_md;
    logic out_v_reg;
    logic [31:0] out_d_reg;
    logic out_z_reg;

    assign en = !out_v_reg || m_tready;
    assign s_tready = en;

    tmf_front #(.CW(CW), .SW(SW)) u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_tvalid),
        .xx(s_tdata[0*CW +: CW]), .xy(s_tdata[1*CW +: CW]), .xz(s_tdata[2*CW +: CW]),
        .yy(s_tdata[3*CW +: CW]), .yz(s_tdata[4*CW +: CW]), .zz(s_tdata[5*CW +: CW]),
        .out_valid(f_v), .s_out(f_s), .num_out(f_n), .md_out(f_md)
    );

    tmf_sqrt #(.SW(SW), .FB(FA_FRAC_BITS)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(f_v),
        .s_in(f_s), .num_in(f_n), .md_in(16'(f_md)),
        .out_valid(q_v), .fa_out(q_fa), .zero_out(q_z), .md_out(q_md)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (en) out_v_reg <= q_v;
        if (en) begin
            out_d_reg <= {q_fa, q_md};
            out_z_reg <= q_z;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tuser  = out_z_reg;

`ifndef ASSERT_OFF
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready) else $error("ready while stalled");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[31:16] == 16'd0)) else $error("fa on zero");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(m_tvalid && !m_tready) && $past(aresetn)) |-> m_tvalid)
        else $error("result lost");
`endif
endmodule

// File: tb/tmf_checker.sv
// Checker for the tensor mean diffusivity / fractional anisotropy block.
// Watches both stream channels, predicts each result and compares it; needs nothing else.
module tmf_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [15:0] mean_diff;
        logic [15:0] frac_aniso;
        logic        zero_tensor;
    } tensor_result_t;

    tensor_result_t expected_results[$];

    function automatic tensor_result_t compute_md_fa(logic [95:0] comps);
        tensor_result_t res;
        logic signed [17:0] trace;
        logic signed [17:0] md;
        logic [17:0] tmag;
        logic [33:0] sq [6];
        logic [127:0] norm_sq;
        logic [127:0] numer;
        logic [127:0] lhs;
        logic [127:0] trial;
        logic [16:0] root;
        logic [16:0] cand;
        logic signed [15:0] c;
        begin
            trace = 0;
            for (int i = 0; i < 6; i++) begin
                c = comps[i*16 +: 16];
                sq[i] = c * c;
                if (i == 0 || i == 3 || i == 5)
                    trace = trace + c;
            end
            norm_sq = sq[0] + sq[3] + sq[5] + 2 * (sq[1] + sq[2] + sq[4]);
            md = trace / 3;
            tmag = trace[17] ? 18'(-trace) : 18'(trace);
            res.mean_diff = md[15:0];
            res.zero_tensor = (norm_sq == 0);
            root = 0;
            if (norm_sq != 0) begin
                numer = 3 * norm_sq - (tmag * tmag);
                lhs = numer << 32;
                for (int b = 16; b >= 0; b--) begin
                    cand = root | (17'd1 << b);
                    trial = 2 * norm_sq * cand * cand;
                    if (trial <= lhs)
                        root = cand;
                end
                if (root > 17'd65535)
                    root = 17'd65535;
            end
            res.frac_aniso = root[15:0];
            return res;
        end
    endfunction

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        tensor_result_t got;
        tensor_result_t want;
        if (aresetn && s_tvalid && s_tready)
            expected_results.push_back(compute_md_fa(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            got.mean_diff = m_tdata[15:0];
            got.frac_aniso = m_tdata[31:16];
            got.zero_tensor = m_tuser;
            if (expected_results.size() == 0) begin
                $error("Result arrived with no request outstanding");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.mean_diff !== want.mean_diff) begin
                    $error("mean_diff expected %0d got %0d",
                           $signed(want.mean_diff), $signed(got.mean_diff));
                    fail_count++;
                end
                if (got.frac_aniso !== want.frac_aniso) begin
                    $error("frac_aniso expected %0d got %0d", want.frac_aniso, got.frac_aniso);
                    fail_count++;
                end
                if (got.zero_tensor !== want.zero_tensor) begin
                    $error("zero_tensor expected %0d got %0d",
                           want.zero_tensor, got.zero_tensor);
                    fail_count++;
                end
            end
        end
    end
endmodule

// File: tb/tb_tensor_md_fa.sv
// Testbench top for tensor_md_fa: drives directed and random tensors with random gaps.
// Depends on tensor_md_fa and tmf_checker, which does all prediction and checking.
module tb_tensor_md_fa;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending;
    int          sent = 0;
    bit          stim_done = 1'b0;

    always #6 aclk = ~aclk;

    tensor_md_fa u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    tmf_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int gap_length();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45) return 0;
            if (roll < 92) return $urandom_range(1, 3);
            return $urandom_range(10, 40);
        end
    endfunction

    function automatic logic [15:0] random_comp(int mode);
        logic [15:0] pick [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'hC000};
        begin
            case (mode)
                0: return 16'($urandom());
                1: return pick[$urandom_range(0, 5)];
                default: return $signed(16'($urandom_range(0, 400))) - 16'sd200;
            endcase
        end
    endfunction

    task automatic send_tensor(logic [95:0] comps);
        int gap;
        begin
            gap = gap_length();
            repeat (gap) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= comps;
            @(posedge aclk);
            while (!s_tready)
                @(posedge aclk);
            sent++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn || ($urandom_range(0, 99) < 70) || stim_done)
            m_tready <= 1'b1;
        else if ($urandom_range(0, 99) < 3)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 2) != 0);
    end

    initial begin
        logic [95:0] t;
        int mode;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_tensor('0);
        send_tensor({6{16'h7FFF}});
        send_tensor({6{16'h8000}});
        send_tensor({16'h7FFF, 32'h0, 16'h7FFF, 16'h0000, 16'h7FFF});
        send_tensor({16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h8000});
        send_tensor({16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF});
        send_tensor({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF});
        send_tensor({16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF});
        send_tensor({16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h0000});
        send_tensor({16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0001});
        send_tensor({16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_tensor({16'hFFFE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
        send_tensor({16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000});
        send_tensor({16'h0005, 16'h0000, 16'h0000, 16'h0002, 16'h0000, 16'h0002});
        for (int i = 0; i < 1350; i++) begin
            if (i == 600) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending != 0)
                    @(posedge aclk);
            end
            mode = $urandom_range(0, 9);
            for (int k = 0; k < 6; k++)
                t[k*16 +: 16] = random_comp(mode < 6 ? 0 : (mode < 8 ? 1 : 2));
            if ($urandom_range(0, 99) < 2)
                t = '0;
            send_tensor(t);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
        while (pending != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
        $display("Sent %0d tensors: field extremes, zero tensors, negative eigenvalues,", sent);
        $display("small and full-range components, with random gaps and output stalls.");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
